// ----- src/usb_idp_pkg.sv -----
// ----------------------------------------------------------------------------
// usb_idp_pkg
// Shared constants, control word layout, microcode table and crc16 step
// for the usb in data packetizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usb_idp_pkg;

  localparam int MAX_PAYLOAD = 8;
  localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  localparam logic [7:0]  SYNC_BYTE = 8'h80;
  localparam logic [7:0]  PID_DATA0 = 8'hC3;
  localparam logic [7:0]  PID_DATA1 = 8'h4B;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam int UCODE_LEN = 9;
  localparam int PC_W      = $clog2(UCODE_LEN);

  localparam logic [PC_W-1:0] STEP_SYNC     = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_PID      = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_PAYLOAD  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_CRC_LO   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_CRC_HI   = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_ZL_SYNC  = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_ZL_PID   = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_ZL_CRC0  = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_ZL_CRC1  = PC_W'(8);

  typedef enum logic [2:0] {
    SRC_SYNC,
    SRC_PID,
    SRC_PAYLOAD,
    SRC_CRC_LO,
    SRC_CRC_HI,
    SRC_ZERO
  } src_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_END_UNLESS_ZLP,
    SEQ_END
  } seq_op_t;

  typedef struct packed {
    src_sel_t        src;
    logic            pkt_end;
    seq_op_t         op;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  // one control word per wire byte slot
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    begin
      w = '{src: SRC_ZERO, pkt_end: 1'b1, op: SEQ_END, target: STEP_SYNC};
      case (pc)
        STEP_SYNC:    w = '{src: SRC_SYNC,    pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_PID:     w = '{src: SRC_PID,     pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_PAYLOAD: w = '{src: SRC_PAYLOAD, pkt_end: 1'b0, op: SEQ_LOOP,
                            target: STEP_PAYLOAD};
        STEP_CRC_LO:  w = '{src: SRC_CRC_LO,  pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_CRC_HI:  w = '{src: SRC_CRC_HI,  pkt_end: 1'b1, op: SEQ_END_UNLESS_ZLP,
                            target: STEP_SYNC};
        STEP_ZL_SYNC: w = '{src: SRC_SYNC,    pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_ZL_PID:  w = '{src: SRC_PID,     pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_ZL_CRC0: w = '{src: SRC_ZERO,    pkt_end: 1'b0, op: SEQ_NEXT,
                            target: STEP_SYNC};
        STEP_ZL_CRC1: w = '{src: SRC_ZERO,    pkt_end: 1'b1, op: SEQ_END,
                            target: STEP_SYNC};
        default:      w = '{src: SRC_ZERO,    pkt_end: 1'b1, op: SEQ_END,
                            target: STEP_SYNC};
      endcase
      return w;
    end
  endfunction

  // reflected crc16, one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    begin
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    end
  endfunction

endpackage

// ----- src/usb_in_data_packetizer_top.sv -----
// ----------------------------------------------------------------------------
// usb_in_data_packetizer_top
// Gathers transfer payload bytes and sends them as usb data packets with
// sync, data0/data1 pid, payload and crc16, plus a trailing zero-length packet when a transfer ends full.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one payload byte per request, with first/last-of-transfer marks and
//           start_data1 (honored on the first byte only).
//   out_* : one wire byte per request; packet_end, transfer_end and run_end
//           mark the end of a packet, of the transfer and of the bytes caused
//           by one input request.
//   A byte that does not close a packet is taken and sends nothing. A byte
//   that closes a packet of n payload bytes starts a microcode program that
//   sends n+4 wire bytes, plus 4 more for a zero-length packet, one per cycle
//   when the receiver is ready, each registered in the output register. The
//   input is held off until the last wire byte of that program is registered,
//   so the step counter and the single output register set the pace.
//   A receiver stall freezes the program; the output register holds its byte.
//   Reset clears the fill count, toggle (data0 next) and sequencer, and sets the crc to its init value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_in_data_packetizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_transfer,
  input  logic       in_start_data1,
  input  logic       in_last_of_transfer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_wire_byte,
  output logic       out_packet_end,
  output logic       out_transfer_end,
  output logic       out_run_end
);

  localparam int FILL_W = usb_idp_pkg::FILL_W;
  localparam int IDX_W  = usb_idp_pkg::IDX_W;
  localparam int PC_W   = usb_idp_pkg::PC_W;

  logic [7:0] payload_mem [usb_idp_pkg::MAX_PAYLOAD];

  logic [FILL_W-1:0] fill_r,    fill_nxt;
  logic [15:0]       crc_r,     crc_nxt;
  logic              toggle_r,  toggle_nxt;
  logic              busy_r,    busy_nxt;
  logic [PC_W-1:0]   pc_r,      pc_nxt;
  logic [IDX_W-1:0]  idx_r,     idx_nxt;
  logic [FILL_W-1:0] len_r,     len_nxt;
  logic [15:0]       crc_out_r, crc_out_nxt;
  logic              zlp_r,     zlp_nxt;
  logic              last_r,    last_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [7:0] out_wire_byte_r;
  logic       out_packet_end_r;
  logic       out_transfer_end_r;
  logic       out_run_end_r;

  logic                    in_fire;
  logic                    seq_fire;
  logic [FILL_W-1:0]       fill_base;
  logic                    wr_en;
  logic [FILL_W-1:0]       fill_new;
  logic [15:0]             crc_new;
  logic                    full;
  usb_idp_pkg::ctl_word_t  ctl;
  logic                    more;
  logic                    seq_done;
  logic [7:0]              byte_sel;
  logic                    tend_sel;
  logic                    rend_sel;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign seq_fire = busy_r && (!out_valid_r || out_ready);

  // input side: gather byte and update crc
  always_comb begin
    fill_base = in_first_of_transfer ? '0 : fill_r;
    wr_en     = fill_base < FILL_W'(usb_idp_pkg::MAX_PAYLOAD);
    fill_new  = wr_en ? fill_base + FILL_W'(1) : fill_base;
    crc_new   = usb_idp_pkg::crc16_byte(in_first_of_transfer ? usb_idp_pkg::CRC_INIT
                                                             : crc_r, in_data_byte);
    full      = fill_new >= FILL_W'(usb_idp_pkg::MAX_PAYLOAD);
  end

  // sequencer decode
  always_comb begin
    ctl  = usb_idp_pkg::ucode_rom(pc_r);
    more = (FILL_W'(idx_r) + FILL_W'(1)) != len_r;
    case (ctl.op)
      usb_idp_pkg::SEQ_END:            seq_done = 1'b1;
      usb_idp_pkg::SEQ_END_UNLESS_ZLP: seq_done = !zlp_r;
      default:                         seq_done = 1'b0;
    endcase
    tend_sel = (ctl.op == usb_idp_pkg::SEQ_END) ||
               ((ctl.op == usb_idp_pkg::SEQ_END_UNLESS_ZLP) && !zlp_r && last_r);
    rend_sel = seq_done;
    case (ctl.src)
      usb_idp_pkg::SRC_SYNC:   byte_sel = usb_idp_pkg::SYNC_BYTE;
      usb_idp_pkg::SRC_PID:    byte_sel = toggle_r ? usb_idp_pkg::PID_DATA1
                                                   : usb_idp_pkg::PID_DATA0;
      usb_idp_pkg::SRC_CRC_LO: byte_sel = crc_out_r[7:0];
      usb_idp_pkg::SRC_CRC_HI: byte_sel = crc_out_r[15:8];
      default:                 byte_sel = 8'h00;
    endcase
  end

  // next-state logic
  always_comb begin
    fill_nxt      = fill_r;
    crc_nxt       = crc_r;
    toggle_nxt    = toggle_r;
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    crc_out_nxt   = crc_out_r;
    zlp_nxt       = zlp_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      if (in_first_of_transfer && in_start_data1) begin
        toggle_nxt = 1'b1;
      end
      if (full || in_last_of_transfer) begin
        fill_nxt    = '0;
        crc_nxt     = usb_idp_pkg::CRC_INIT;
        busy_nxt    = 1'b1;
        pc_nxt      = usb_idp_pkg::STEP_SYNC;
        idx_nxt     = '0;
        len_nxt     = fill_new;
        crc_out_nxt = ~crc_new;
        zlp_nxt     = full && in_last_of_transfer;
        last_nxt    = in_last_of_transfer;
      end else begin
        fill_nxt = fill_new;
        crc_nxt  = crc_new;
      end
    end

    if (seq_fire) begin
      out_valid_nxt = 1'b1;
      if (ctl.src == usb_idp_pkg::SRC_PID) begin
        toggle_nxt = !toggle_r;
      end
      if (ctl.src == usb_idp_pkg::SRC_PAYLOAD) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (seq_done) begin
        busy_nxt = 1'b0;
      end else if ((ctl.op == usb_idp_pkg::SEQ_LOOP) && more) begin
        pc_nxt = ctl.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      crc_r       <= usb_idp_pkg::CRC_INIT;
      toggle_r    <= 1'b0;
      busy_r      <= 1'b0;
      pc_r        <= usb_idp_pkg::STEP_SYNC;
      idx_r       <= '0;
      len_r       <= '0;
      zlp_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      crc_r       <= crc_nxt;
      toggle_r    <= toggle_nxt;
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      zlp_r       <= zlp_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_out_r <= crc_out_nxt;
  end

  // payload store write
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      payload_mem[fill_base[IDX_W-1:0]] <= in_data_byte;
    end
  end

  // output register, payload read
  always_ff @(posedge clk) begin
    if (seq_fire) begin
      out_wire_byte_r    <= (ctl.src == usb_idp_pkg::SRC_PAYLOAD) ? payload_mem[idx_r]
                                                                  : byte_sel;
      out_packet_end_r   <= ctl.pkt_end;
      out_transfer_end_r <= tend_sel;
      out_run_end_r      <= rend_sel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_wire_byte    = out_wire_byte_r;
  assign out_packet_end   = out_packet_end_r;
  assign out_transfer_end = out_transfer_end_r;
  assign out_run_end      = out_run_end_r;

  // checks
  a_run_end_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_run_end_r |-> out_packet_end_r)
    else $error("run_end without packet_end");

  a_tend_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_transfer_end_r |-> out_packet_end_r)
    else $error("transfer_end without packet_end");

  a_program_ends_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r && out_run_end_r)
    else $error("sequencer stopped without run_end");

  a_payload_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (pc_r == usb_idp_pkg::STEP_PAYLOAD) |-> (FILL_W'(idx_r) < len_r))
    else $error("payload index past packet length");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the usb in data packetizer: directed table, then
// random transfers, with a behavioral packet predictor and random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int          MAX_PAYLOAD = usb_idp_pkg::MAX_PAYLOAD;
  localparam logic [7:0]  SYNC_BYTE   = usb_idp_pkg::SYNC_BYTE;
  localparam logic [7:0]  PID_DATA0   = usb_idp_pkg::PID_DATA0;
  localparam logic [7:0]  PID_DATA1   = usb_idp_pkg::PID_DATA1;
  localparam logic [15:0] CRC_POLY    = usb_idp_pkg::CRC_POLY;
  localparam logic [15:0] CRC_INIT    = usb_idp_pkg::CRC_INIT;

  localparam int         N_RANDOM  = 405;
  localparam int         HOLD_CYC  = 300;
  localparam int         IDLE_PCT  = 38;
  localparam logic [7:0] NO_PID    = 8'h00;

  typedef struct {
    logic [7:0] data;
    bit         pkt_end;
    bit         xfer_end;
    bit         run_end;
  } wire_rec_t;

  typedef struct {
    logic [7:0] data;
    bit         first;
    bit         sd1;
    bit         last;
    logic [7:0] pid;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_first_of_transfer;
  logic       in_start_data1;
  logic       in_last_of_transfer;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_wire_byte;
  logic       out_packet_end;
  logic       out_transfer_end;
  logic       out_run_end;

  wire_rec_t  wire_q[$];
  stim_row_t  dir_rows[$];

  // predictor state
  logic [7:0]  m_store [MAX_PAYLOAD];
  int          m_fill;
  logic [15:0] m_crc;
  bit          m_data1;

  int n_err;
  int n_in;
  int n_wire;
  int n_pkt;
  int n_xfer;
  int n_zlp;
  bit idle_on;
  bit rx_hold_req;

  usb_in_data_packetizer_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_first_of_transfer (in_first_of_transfer),
    .in_start_data1       (in_start_data1),
    .in_last_of_transfer  (in_last_of_transfer),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_wire_byte        (out_wire_byte),
    .out_packet_end       (out_packet_end),
    .out_transfer_end     (out_transfer_end),
    .out_run_end          (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_err++;
  endtask

  task automatic push_wire(input logic [7:0] b, input bit pe, input bit te);
    wire_rec_t r;
    r.data     = b;
    r.pkt_end  = pe;
    r.xfer_end = te;
    r.run_end  = 1'b0;
    wire_q.push_back(r);
  endtask

  task automatic push_header();
    push_wire(SYNC_BYTE, 1'b0, 1'b0);
    push_wire(m_data1 ? PID_DATA1 : PID_DATA0, 1'b0, 1'b0);
    m_data1 = !m_data1;
  endtask

  task automatic predict_packets(input logic [7:0] d, input bit f, input bit s,
                                 input bit l);
    logic [15:0] c;
    logic [15:0] fcs;
    bit          full;
    bit          fb;
    if (f) begin
      m_fill = 0;
      m_crc  = CRC_INIT;
      if (s) begin
        m_data1 = 1'b1;
      end
    end
    if (m_fill < MAX_PAYLOAD) begin
      m_store[m_fill] = d;
      m_fill++;
    end
    c = m_crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    m_crc = c;
    full = (m_fill >= MAX_PAYLOAD);
    if (!full && !l) begin
      return;
    end
    fcs = ~m_crc;
    push_header();
    for (int i = 0; i < m_fill; i++) begin
      push_wire(m_store[i], 1'b0, 1'b0);
    end
    push_wire(fcs[7:0], 1'b0, 1'b0);
    push_wire(fcs[15:8], 1'b1, l && !full);
    // transfer ended on a full packet: trailing zero-length packet
    if (l && full) begin
      push_header();
      push_wire(8'h00, 1'b0, 1'b0);
      push_wire(8'h00, 1'b1, 1'b1);
      n_zlp++;
    end
    m_fill = 0;
    m_crc  = CRC_INIT;
    wire_q[wire_q.size() - 1].run_end = 1'b1;
  endtask

  // offer one request and return at the edge where it is taken
  task automatic offer_byte(input logic [7:0] d, input bit f, input bit s,
                            input bit l);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data_byte         <= d;
    in_first_of_transfer <= f;
    in_start_data1       <= s;
    in_last_of_transfer  <= l;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    n_in++;
  endtask

  task automatic send_and_predict(input logic [7:0] d, input bit f, input bit s,
                                  input bit l);
    offer_byte(d, f, s, l);
    predict_packets(d, f, s, l);
  endtask

  task automatic add_row(input logic [7:0] d, input bit f, input bit s,
                         input bit l, input logic [7:0] p);
    stim_row_t r;
    r.data  = d;
    r.first = f;
    r.sd1   = s;
    r.last  = l;
    r.pid   = p;
    dir_rows.push_back(r);
  endtask

  task automatic drain_wire_q();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wire_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // receiver
  initial begin
    int hold_left;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_left = HOLD_CYC; hold_left > 0; hold_left--) begin
          @(posedge clk);
        end
      end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    wire_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      n_wire++;
      if (out_packet_end) begin
        n_pkt++;
      end
      if (out_transfer_end) begin
        n_xfer++;
      end
      if (wire_q.size() == 0) begin
        flag_error($sformatf("unexpected wire byte %02h", out_wire_byte));
      end else begin
        want = wire_q.pop_front();
        if (out_wire_byte !== want.data) begin
          flag_error($sformatf("wire_byte %02h, want %02h", out_wire_byte, want.data));
        end
        if (out_packet_end !== want.pkt_end) begin
          flag_error($sformatf("packet_end %b, want %b", out_packet_end, want.pkt_end));
        end
        if (out_transfer_end !== want.xfer_end) begin
          flag_error($sformatf("transfer_end %b, want %b", out_transfer_end,
                               want.xfer_end));
        end
        if (out_run_end !== want.run_end) begin
          flag_error($sformatf("run_end %b, want %b", out_run_end, want.run_end));
        end
      end
    end
  end

  initial begin
    int        base;
    int        sent;
    int        len;
    bit        mark;
    bit        sd1;
    bit        hold_done;
    bit        pause_done;
    stim_row_t r;

    n_err       = 0;
    n_in        = 0;
    n_wire      = 0;
    n_pkt       = 0;
    n_xfer      = 0;
    n_zlp       = 0;
    idle_on     = 1'b1;
    rx_hold_req = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    m_fill      = 0;
    m_crc       = CRC_INIT;
    m_data1     = 1'b0;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      m_store[i] = 8'h00;
    end

    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_data_byte         <= 8'h00;
    in_first_of_transfer <= 1'b0;
    in_start_data1       <= 1'b0;
    in_last_of_transfer  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte transfers, data0 after reset, then forced data1
    add_row(8'h00, 1'b1, 1'b0, 1'b1, PID_DATA0);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, PID_DATA1);
    // full packet mid transfer, then a one-byte tail
    add_row(8'h01, 1'b1, 1'b0, 1'b0, NO_PID);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h7F, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'hFE, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h55, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'hAA, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h10, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'hEF, 1'b0, 1'b0, 1'b0, PID_DATA0);
    add_row(8'h3C, 1'b0, 1'b0, 1'b1, PID_DATA1);
    // transfer ending on a full packet
    add_row(8'h11, 1'b1, 1'b1, 1'b0, NO_PID);
    add_row(8'h22, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h44, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h88, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h96, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h69, 1'b0, 1'b0, 1'b1, PID_DATA1);
    // restart while half gathered
    add_row(8'hA5, 1'b1, 1'b0, 1'b0, NO_PID);
    add_row(8'h5A, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'hC3, 1'b0, 1'b0, 1'b0, NO_PID);
    add_row(8'h4B, 1'b1, 1'b0, 1'b1, PID_DATA1);
    // start_data1 without first mark, unmarked transfer keeps the toggle
    add_row(8'h77, 1'b0, 1'b1, 1'b0, NO_PID);
    add_row(8'h88, 1'b0, 1'b0, 1'b1, PID_DATA0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      offer_byte(r.data, r.first, r.sd1, r.last);
      base = wire_q.size();
      predict_packets(r.data, r.first, r.sd1, r.last);
      if (r.pid != NO_PID && wire_q.size() > base + 1) begin
        wire_q[base + 1].data = r.pid;
      end
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      if (!hold_done && sent >= 120) begin
        rx_hold_req = 1'b1;
        hold_done   = 1'b1;
      end
      if (!pause_done && sent >= 300) begin
        drain_wire_q();
        pause_done = 1'b1;
      end
      idle_on = !(sent >= 200 && sent < 260);
      if ($urandom_range(99) < 15) begin
        send_and_predict(8'($urandom_range(255)), $urandom_range(99) < 25,
                         1'($urandom_range(1)), $urandom_range(99) < 25);
        sent++;
      end else begin
        if ($urandom_range(99) < 30) begin
          len = 8 * $urandom_range(1, 3);
        end else begin
          len = $urandom_range(1, 20);
        end
        mark = ($urandom_range(99) < 90);
        sd1  = 1'($urandom_range(1));
        for (int j = 0; j < len; j++) begin
          send_and_predict(8'($urandom_range(255)), mark && j == 0,
                           (j == 0) ? sd1 : 1'($urandom_range(1)), j == len - 1);
          sent++;
        end
      end
    end

    drain_wire_q();
    repeat (40) @(posedge clk);
    if (wire_q.size() != 0) begin
      flag_error($sformatf("%0d wire bytes never arrived", wire_q.size()));
    end

    $display("run: %0d input bytes, %0d wire bytes, %0d packets (%0d zero-length)",
             n_in, n_wire, n_pkt, n_zlp);
    $display("run: %0d transfer ends, receiver hold of %0d cycles, %0d mismatches",
             n_xfer, HOLD_CYC, n_err);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- usb_in_data_packetizer_top.f -----
src/usb_idp_pkg.sv
src/usb_in_data_packetizer_top.sv
tb/tb.sv
